### rtl/eepc_pkg.sv
// Shared types and constants for the EEPROM programmer command engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package eepc_pkg;

  localparam int unsigned AddrMaxBits = 16;
  localparam int unsigned CfgDataBits = 12;
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned PollBits = 12;

  localparam logic [CfgIndexBits-1:0] REG_READ_CODE        = 3'd0;
  localparam logic [CfgIndexBits-1:0] REG_WRITE_CODE       = 3'd1;
  localparam logic [CfgIndexBits-1:0] REG_PROTECT_ON_CODE  = 3'd2;
  localparam logic [CfgIndexBits-1:0] REG_PROTECT_OFF_CODE = 3'd3;
  localparam logic [CfgIndexBits-1:0] REG_POLL_LIMIT       = 3'd4;

  localparam logic [7:0] RESET_READ_CODE        = 8'd82;
  localparam logic [7:0] RESET_WRITE_CODE       = 8'd87;
  localparam logic [7:0] RESET_PROTECT_ON_CODE  = 8'd69;
  localparam logic [7:0] RESET_PROTECT_OFF_CODE = 8'd68;
  localparam logic [PollBits-1:0] RESET_POLL_LIMIT = 12'd2500;

  localparam logic [15:0] SDP_ADDR_A = 16'h5555;
  localparam logic [15:0] SDP_ADDR_B = 16'h2AAA;
  localparam logic [7:0] SDP_DATA_AA = 8'hAA;
  localparam logic [7:0] SDP_DATA_55 = 8'h55;
  localparam logic [7:0] SDP_DATA_A0 = 8'hA0;
  localparam logic [7:0] SDP_DATA_80 = 8'h80;
  localparam logic [7:0] SDP_DATA_20 = 8'h20;
  localparam logic [7:0] REPLY_ENABLED  = 8'h45;
  localparam logic [7:0] REPLY_DISABLED = 8'h44;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE_POLL,
    OP_REPLY,
    OP_SDP_ON,
    OP_SDP_OFF
  } op_t;

  typedef struct packed {
    logic       func;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] mem_address;
    logic [7:0]  data;
    logic        last;
  } out_t;

  typedef struct packed {
    op_t                   op;
    logic [AddrMaxBits-1:0] addr;
    logic [7:0]            data;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/eepc_front.sv
// Front end: accepts input transactions, tracks command phase, holds the
// configuration registers and issues commands. Depends on eepc_pkg.
`default_nettype none

module eepc_front #(
  parameter int unsigned ADDRESS_BITS = 15
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire eepc_pkg::in_t                     in_item,
  input  wire logic                              cfg_we,
  input  wire logic [eepc_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [eepc_pkg::CfgDataBits-1:0]  cfg_data,
  output logic                                   cmd_valid,
  output eepc_pkg::cmd_t                         cmd
);
  import eepc_pkg::*;

  localparam logic [AddrMaxBits:0] MaskWide = (17'd1 << ADDRESS_BITS) - 17'd1;
  localparam logic [AddrMaxBits-1:0] AddrMask = MaskWide[AddrMaxBits-1:0];

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_WRITE_DATA,
    PH_WAIT_READ,
    PH_WAIT_POLL,
    PH_WAIT_FINAL
  } phase_t;

  phase_t                 phase, phase_next;
  logic [7:0]             held_opcode, held_opcode_next;
  logic [AddrMaxBits-1:0] target_address, target_address_next;
  logic [7:0]             write_value, write_value_next;
  logic [PollBits-1:0]    poll_count, poll_count_next;

  logic [7:0]          read_code, write_code, protect_on_code, protect_off_code;
  logic [PollBits-1:0] poll_limit;

  logic [AddrMaxBits-1:0] low_address;

  assign low_address = (target_address | {8'd0, in_item.value}) & AddrMask;

  always_comb begin
    phase_next = phase;
    held_opcode_next = held_opcode;
    target_address_next = target_address;
    write_value_next = write_value;
    poll_count_next = poll_count;
    cmd_valid = 1'b0;
    cmd.op = OP_READ;
    cmd.addr = target_address;
    cmd.data = in_item.value;
    if (accept) begin
      if (!in_item.func) begin
        unique case (phase)
          PH_IDLE: begin
            held_opcode_next = in_item.value;
            priority if (in_item.value == protect_on_code) begin
              cmd_valid = 1'b1;
              cmd.op = OP_SDP_ON;
            end else if (in_item.value == protect_off_code) begin
              cmd_valid = 1'b1;
              cmd.op = OP_SDP_OFF;
            end else begin
              phase_next = PH_ADDR_HI;
            end
          end
          PH_ADDR_HI: begin
            target_address_next = {in_item.value, 8'd0} & AddrMask;
            phase_next = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            target_address_next = low_address;
            priority if (held_opcode == read_code) begin
              cmd_valid = 1'b1;
              cmd.op = OP_READ;
              cmd.addr = low_address;
              phase_next = PH_WAIT_READ;
            end else if (held_opcode == write_code) begin
              phase_next = PH_WRITE_DATA;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_WRITE_DATA: begin
            write_value_next = in_item.value;
            poll_count_next = 12'd1;
            cmd_valid = 1'b1;
            cmd.op = OP_WRITE_POLL;
            phase_next = PH_WAIT_POLL;
          end
          default: ;
        endcase
      end else begin
        unique case (phase)
          PH_WAIT_READ, PH_WAIT_FINAL: begin
            cmd_valid = 1'b1;
            cmd.op = OP_REPLY;
            phase_next = PH_IDLE;
          end
          PH_WAIT_POLL: begin
            cmd_valid = 1'b1;
            cmd.op = OP_READ;
            if (in_item.value == write_value || poll_count >= poll_limit) begin
              phase_next = PH_WAIT_FINAL;
            end else begin
              poll_count_next = poll_count + 12'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held_opcode <= 8'd0;
      target_address <= '0;
      write_value <= 8'd0;
      poll_count <= '0;
      read_code <= RESET_READ_CODE;
      write_code <= RESET_WRITE_CODE;
      protect_on_code <= RESET_PROTECT_ON_CODE;
      protect_off_code <= RESET_PROTECT_OFF_CODE;
      poll_limit <= RESET_POLL_LIMIT;
    end else begin
      phase <= phase_next;
      held_opcode <= held_opcode_next;
      target_address <= target_address_next;
      write_value <= write_value_next;
      poll_count <= poll_count_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_READ_CODE:        read_code <= cfg_data[7:0];
          REG_WRITE_CODE:       write_code <= cfg_data[7:0];
          REG_PROTECT_ON_CODE:  protect_on_code <= cfg_data[7:0];
          REG_PROTECT_OFF_CODE: protect_off_code <= cfg_data[7:0];
          REG_POLL_LIMIT:       poll_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### rtl/eepc_cmd_queue.sv
// Command queue between front end and back end.
// Small register FIFO of eepc_pkg::cmd_t entries. Depends on eepc_pkg.
`default_nettype none

module eepc_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire eepc_pkg::cmd_t wr_cmd,
  output logic                full,
  input  wire logic           rd,
  output logic                head_valid,
  output eepc_pkg::cmd_t      head
);
  import eepc_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrBits = $clog2(Depth);

  cmd_t               entries [Depth];
  logic [PtrBits-1:0] wr_ptr, rd_ptr;
  logic [PtrBits:0]   count;

  assign full = (count == (PtrBits + 1)'(Depth));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PtrBits + 1)'(wr) - (PtrBits + 1)'(rd);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(wr && full && !rd))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(rd && !head_valid))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst)
    count <= (PtrBits + 1)'(Depth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

### rtl/eepc_back.sv
// Back end: expands queued commands into results, one per cycle unless
// stalled, through a registered output stage. Depends on eepc_pkg.
`default_nettype none

module eepc_back #(
  parameter int unsigned ADDRESS_BITS = 15
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire eepc_pkg::cmd_t head,
  output logic                q_rd,
  output logic                out_valid,
  output eepc_pkg::out_t      out_item,
  input  wire logic           out_take
);
  import eepc_pkg::*;

  localparam logic [AddrMaxBits:0] MaskWide = (17'd1 << ADDRESS_BITS) - 17'd1;
  localparam logic [AddrMaxBits-1:0] AddrMask = MaskWide[AddrMaxBits-1:0];

  logic [2:0]             step;
  logic [2:0]             last_step;
  logic                   load;
  logic [1:0]             res_kind;
  logic [AddrMaxBits-1:0] res_addr;
  logic [7:0]             res_data;
  out_t                   res;

  always_comb begin
    res_kind = KIND_READ;
    res_addr = head.addr;
    res_data = 8'd0;
    last_step = 3'd0;
    unique case (head.op)
      OP_READ: ;
      OP_REPLY: begin
        res_kind = KIND_REPLY;
        res_addr = '0;
        res_data = head.data;
      end
      OP_WRITE_POLL: begin
        last_step = 3'd1;
        if (step == 3'd0) begin
          res_kind = KIND_WRITE;
          res_data = head.data;
        end
      end
      OP_SDP_ON: begin
        last_step = 3'd3;
        res_kind = KIND_WRITE;
        unique case (step)
          3'd0: begin res_addr = SDP_ADDR_A; res_data = SDP_DATA_AA; end
          3'd1: begin res_addr = SDP_ADDR_B; res_data = SDP_DATA_55; end
          3'd2: begin res_addr = SDP_ADDR_A; res_data = SDP_DATA_A0; end
          default: begin
            res_kind = KIND_REPLY;
            res_addr = '0;
            res_data = REPLY_ENABLED;
          end
        endcase
      end
      OP_SDP_OFF: begin
        last_step = 3'd6;
        res_kind = KIND_WRITE;
        unique case (step)
          3'd0: begin
            res_kind = KIND_REPLY;
            res_addr = '0;
            res_data = REPLY_DISABLED;
          end
          3'd1: begin res_addr = SDP_ADDR_A; res_data = SDP_DATA_AA; end
          3'd2: begin res_addr = SDP_ADDR_B; res_data = SDP_DATA_55; end
          3'd3: begin res_addr = SDP_ADDR_A; res_data = SDP_DATA_80; end
          3'd4: begin res_addr = SDP_ADDR_A; res_data = SDP_DATA_AA; end
          3'd5: begin res_addr = SDP_ADDR_B; res_data = SDP_DATA_55; end
          default: begin res_addr = SDP_ADDR_A; res_data = SDP_DATA_20; end
        endcase
      end
      default: ;
    endcase
    res.kind = res_kind;
    res.mem_address = res_addr[14:0] & AddrMask[14:0];
    res.data = res_data;
    res.last = (step == last_step);
  end

  assign load = head_valid && (!out_valid || out_take);
  assign q_rd = load && res.last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step <= res.last ? 3'd0 : step + 3'd1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) head_valid |-> step <= last_step)
    else $error("step beyond command length");
  assert property (@(posedge clk) disable iff (rst) !head_valid |-> step == 3'd0)
    else $error("step held with no command");
  assert property (@(posedge clk) disable iff (rst) q_rd |=> out_valid && out_item.last)
    else $error("command retired without last result");

endmodule

`default_nettype wire

### rtl/eeprom_programmer_command_engine.sv
// Command engine: one input transaction per cycle while full is low; commands
// queue in a 4-entry FIFO; results leave through a registered output stage.
// The back-end sequencer sets throughput, one result per step of a command
// (SDP off 7, SDP on 4, write 2, others 1), one per cycle while pop keeps up.
// Synchronous reset empties queue and output, restores register defaults.
// Depends on eepc_pkg, eepc_front, eepc_cmd_queue, eepc_back.
`default_nettype none

module eeprom_programmer_command_engine #(
  parameter int unsigned ADDRESS_BITS = 15
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire eepc_pkg::in_t                     in_item,
  output logic                                   empty,
  input  wire logic                              pop,
  output eepc_pkg::out_t                         out_item,
  input  wire logic                              cfg_we,
  input  wire logic [eepc_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [eepc_pkg::CfgDataBits-1:0]  cfg_data
);
  import eepc_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_rd;
  logic head_valid;
  cmd_t head;
  logic out_valid;

  assign accept = push && !full;
  assign empty = !out_valid;

  eepc_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .in_item(in_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd(cmd)
  );

  eepc_cmd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr(cmd_valid),
    .wr_cmd(cmd),
    .full(full),
    .rd(q_rd),
    .head_valid(head_valid),
    .head(head)
  );

  eepc_back #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head(head),
    .q_rd(q_rd),
    .out_valid(out_valid),
    .out_item(out_item),
    .out_take(pop)
  );

endmodule

`default_nettype wire

### sim/tb_eeprom_programmer_command_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the EEPROM programmer command engine: feeds host
// command bytes and memory read data, predicts every request and reply.
// Depends on eepc_pkg and rtl/eeprom_programmer_command_engine.sv.
module tb_eeprom_programmer_command_engine;
  import eepc_pkg::*;

  localparam int unsigned AddrBits = 15;
  localparam int unsigned StallMax = 8;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumRegs = 5;
  localparam int unsigned NumRows = 22;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_WRITE_DATA,
    PH_WAIT_READ,
    PH_WAIT_POLL,
    PH_WAIT_FINAL
  } phase_t;

  typedef struct {
    logic       func;
    logic [7:0] value;
    bit         typed;
    bit         has_res;
    out_t       res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_item;
  logic cfg_we = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  logic [7:0] code_read, code_write, code_on, code_off;
  logic [PollBits-1:0] limit_polls;
  phase_t eng_phase;
  logic [7:0] eng_opcode, eng_wdata;
  logic [AddrBits-1:0] eng_addr;
  logic [PollBits-1:0] eng_polls;

  out_t step_results[$];
  out_t pending_results[$];
  row_t script [NumRows];

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int unsigned pop_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned items_taken = 0;
  int unsigned settings_loaded = 0;
  int unsigned seen_replies = 0;
  int unsigned seen_writes = 0;
  int unsigned seen_reads = 0;

  eeprom_programmer_command_engine #(
    .ADDRESS_BITS(AddrBits)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_result(kind_t k, logic [AddrBits-1:0] a, logic [7:0] d);
    out_t r;
    r.kind = k;
    r.mem_address = 15'(a);
    r.data = d;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void predict_engine(input in_t item, output bit taken);
    out_t r;
    step_results.delete();
    taken = 1'b1;
    if (!item.func) begin
      case (eng_phase)
        PH_IDLE: begin
          eng_opcode = item.value;
          if (item.value == code_on) begin
            add_result(KIND_WRITE, SDP_ADDR_A[AddrBits-1:0], SDP_DATA_AA);
            add_result(KIND_WRITE, SDP_ADDR_B[AddrBits-1:0], SDP_DATA_55);
            add_result(KIND_WRITE, SDP_ADDR_A[AddrBits-1:0], SDP_DATA_A0);
            add_result(KIND_REPLY, '0, REPLY_ENABLED);
          end else if (item.value == code_off) begin
            add_result(KIND_REPLY, '0, REPLY_DISABLED);
            add_result(KIND_WRITE, SDP_ADDR_A[AddrBits-1:0], SDP_DATA_AA);
            add_result(KIND_WRITE, SDP_ADDR_B[AddrBits-1:0], SDP_DATA_55);
            add_result(KIND_WRITE, SDP_ADDR_A[AddrBits-1:0], SDP_DATA_80);
            add_result(KIND_WRITE, SDP_ADDR_A[AddrBits-1:0], SDP_DATA_AA);
            add_result(KIND_WRITE, SDP_ADDR_B[AddrBits-1:0], SDP_DATA_55);
            add_result(KIND_WRITE, SDP_ADDR_A[AddrBits-1:0], SDP_DATA_20);
          end else begin
            eng_phase = PH_ADDR_HI;
          end
        end
        PH_ADDR_HI: begin
          eng_addr = AddrBits'({item.value, 8'h00});
          eng_phase = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          eng_addr = eng_addr | AddrBits'(item.value);
          if (eng_opcode == code_read) begin
            add_result(KIND_READ, eng_addr, 8'h00);
            eng_phase = PH_WAIT_READ;
          end else if (eng_opcode == code_write) begin
            eng_phase = PH_WRITE_DATA;
          end else begin
            eng_phase = PH_IDLE;
          end
        end
        PH_WRITE_DATA: begin
          eng_wdata = item.value;
          add_result(KIND_WRITE, eng_addr, item.value);
          add_result(KIND_READ, eng_addr, 8'h00);
          eng_polls = 12'd1;
          eng_phase = PH_WAIT_POLL;
        end
        default: taken = 1'b0;
      endcase
    end else begin
      case (eng_phase)
        PH_WAIT_READ, PH_WAIT_FINAL: begin
          add_result(KIND_REPLY, '0, item.value);
          eng_phase = PH_IDLE;
        end
        PH_WAIT_POLL: begin
          if (item.value == eng_wdata || eng_polls >= limit_polls) begin
            eng_phase = PH_WAIT_FINAL;
          end else begin
            eng_polls = eng_polls + 1'b1;
          end
          add_result(KIND_READ, eng_addr, 8'h00);
        end
        default: taken = 1'b0;
      endcase
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endfunction

  function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Shape each item on what the engine is waiting for, with some noise.
  function automatic in_t pick_item();
    in_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.value = 8'($urandom);
    it.func = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        if (r < 8) it.func = 1'b1;
        else if (r < 33) it.value = code_read;
        else if (r < 63) it.value = code_write;
        else if (r < 73) it.value = code_on;
        else if (r < 83) it.value = code_off;
      end
      PH_WAIT_READ, PH_WAIT_FINAL: it.func = (r >= 8);
      PH_WAIT_POLL: begin
        it.func = (r >= 8);
        if (r >= 8 && r < 45) it.value = eng_wdata;
      end
      default: it.func = (r < 5);
    endcase
    return it;
  endfunction

  task automatic send_item(input in_t item, input bit typed, input bit has_res,
                           input out_t res, output bit taken);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, StallMax) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full);
    predict_engine(item, taken);
    if (taken) items_taken++;
    if (typed) begin
      if (has_res) pending_results.push_back(res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] rc, input logic [7:0] wc,
                               input logic [7:0] onc, input logic [7:0] offc,
                               input logic [PollBits-1:0] lim);
    logic [CfgIndexBits-1:0] regs [NumRegs];
    logic [CfgDataBits-1:0] vals [NumRegs];
    regs = '{REG_READ_CODE, REG_WRITE_CODE, REG_PROTECT_ON_CODE,
             REG_PROTECT_OFF_CODE, REG_POLL_LIMIT};
    vals = '{CfgDataBits'(rc), CfgDataBits'(wc), CfgDataBits'(onc),
             CfgDataBits'(offc), CfgDataBits'(lim)};
    for (int k = 0; k < NumRegs; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    code_read = rc;
    code_write = wc;
    code_on = onc;
    code_off = offc;
    limit_polls = lim;
    settings_loaded++;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned done;
    bit taken;
    done = 0;
    while (done < n_items || eng_phase != PH_IDLE) begin
      if ($urandom_range(0, 29) == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      send_item(pick_item(), 1'b0, 1'b0, '0, taken);
      if (taken) done++;
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (pop && !empty) begin
        case (out_item.kind)
          KIND_REPLY: seen_replies++;
          KIND_WRITE: seen_writes++;
          KIND_READ:  seen_reads++;
          default: ;
        endcase
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0h addr %0h data %0h last %0h",
                   $time, out_item.kind, out_item.mem_address, out_item.data, out_item.last);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          field_check("kind", 16'(want.kind), 16'(out_item.kind));
          field_check("mem_address", 16'(want.mem_address), 16'(out_item.mem_address));
          field_check("data", 16'(want.data), 16'(out_item.data));
          field_check("last", 16'(want.last), 16'(out_item.last));
        end
        pop_hold = recv_idle ? $urandom_range(0, StallMax) : 0;
      end else if (pop_hold != 0) begin
        pop_hold--;
      end
      pop <= (pop_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit taken;
    script = '{
      '{1'b0, RESET_READ_CODE, 1'b1, 1'b0, '0},
      '{1'b0, 8'hFF, 1'b1, 1'b0, '0},
      '{1'b0, 8'hFF, 1'b1, 1'b1, '{KIND_READ, 15'h7FFF, 8'h00, 1'b1}},
      '{1'b0, 8'h12, 1'b1, 1'b0, '0},
      '{1'b1, 8'hFF, 1'b1, 1'b1, '{KIND_REPLY, 15'h0000, 8'hFF, 1'b1}},
      '{1'b1, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, RESET_WRITE_CODE, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, 8'h5A, 1'b0, 1'b0, '0},
      '{1'b1, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, 8'hA5, 1'b1, 1'b1, '{KIND_REPLY, 15'h0000, 8'hA5, 1'b1}},
      '{1'b0, RESET_PROTECT_ON_CODE, 1'b0, 1'b0, '0},
      '{1'b0, RESET_PROTECT_OFF_CODE, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h80, 1'b1, 1'b0, '0},
      '{1'b0, 8'h01, 1'b1, 1'b0, '0},
      '{1'b0, RESET_READ_CODE, 1'b1, 1'b0, '0},
      '{1'b0, 8'h80, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b1, '{KIND_READ, 15'h0000, 8'h00, 1'b1}},
      '{1'b1, 8'h00, 1'b1, 1'b1, '{KIND_REPLY, 15'h0000, 8'h00, 1'b1}}
    };
    code_read = RESET_READ_CODE;
    code_write = RESET_WRITE_CODE;
    code_on = RESET_PROTECT_ON_CODE;
    code_off = RESET_PROTECT_OFF_CODE;
    limit_polls = RESET_POLL_LIMIT;
    eng_phase = PH_IDLE;
    eng_opcode = '0;
    eng_addr = '0;
    eng_wdata = '0;
    eng_polls = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_item('{script[i].func, script[i].value}, script[i].typed,
                script[i].has_res, script[i].res, taken);
    end
    drain();

    // Codes at the byte extremes; a zero poll limit behaves as one.
    load_settings(8'h00, 8'hFF, 8'h01, 8'hFE, 12'd0);
    run_random(35);
    drain();
    load_settings(8'hFF, 8'h00, 8'h80, 8'h7F, 12'd1);
    run_random(35);
    drain();
    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  PollBits'($urandom_range(2, 6)));
    run_random(40);
    drain();
    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 12'd4095);
    run_random(35);
    drain();
    // Shared codes: read wins over write, enable wins over disable.
    load_settings(RESET_READ_CODE, RESET_READ_CODE, RESET_PROTECT_ON_CODE,
                  RESET_PROTECT_ON_CODE, 12'd3);
    run_random(35);
    drain();

    $display("Covered %0d accepted items under %0d register settings plus reset values.",
             items_taken, settings_loaded);
    $display("Checked %0d memory reads, %0d memory writes and %0d host replies.",
             seen_reads, seen_writes, seen_replies);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
